// ----- hdl/goe_pkg.sv -----
// Package for the glyph outline expander: constants, packed result type and
// the row decode and cell packing functions. No dependencies.
package goe_pkg;

	localparam int COLS          = 12;
	localparam int ROW_BITS_W    = 16;
	localparam int ROW_IDX_W     = 4;
	localparam int CELLS_W       = 48;
	localparam int OUT_DATA_W    = 56;
	localparam int MAX_ROWS_DEF  = 12;

	typedef logic [COLS-1:0]      col_mask_t;
	typedef logic [CELLS_W-1:0]   cells_t;
	typedef logic [ROW_IDX_W-1:0] row_idx_t;

	typedef struct packed {
		logic     done;
		row_idx_t row;
		cells_t   cells;
	} result_t;

	// Bit k set when pixel k+1 is inked.
	function automatic col_mask_t to_columns(input logic [ROW_BITS_W-1:0] bits);
		col_mask_t m;
		m = '0;
		for (int k = 0; k < 8; k++) begin
			m[k] = bits[7-k];
		end
		for (int k = 0; k < 4; k++) begin
			m[8+k] = bits[15-k];
		end
		return m;
	endfunction

	function automatic col_mask_t spread_full(input col_mask_t m);
		return m | (m << 1) | (m << 2);
	endfunction

	function automatic col_mask_t spread_sides(input col_mask_t m);
		return m | (m << 2);
	endfunction

	// Pack one cell row from the masks at offsets 0, 1 and 2 above it.
	function automatic cells_t pack_cells(input col_mask_t at0, input col_mask_t at1,
			input col_mask_t at2, input logic odd);
		col_mask_t c1;
		col_mask_t c2;
		cells_t    w;
		c2 = spread_full(at0) | spread_sides(at1) | spread_full(at2);
		c1 = at1 << 1;
		w  = '0;
		for (int p = 0; p < COLS; p++) begin
			if (odd) begin
				w[4*p +: 4] = {c2[p], c1[p], 2'b00};
			end else begin
				w[4*p +: 4] = {2'b00, c2[p], c1[p]};
			end
		end
		return w;
	endfunction

endpackage

// ----- hdl/glyph_outline_expander.sv -----
// Glyph outline expander top level: row decode, outline cell generation and
// output register with trailing-row sequencing. Depends on goe_pkg.
//
// Takes one glyph row per cycle and returns one cell row per cycle through a
// single output register; ready follows the output side, so rows stream at
// full rate while the sink keeps up. The final row of a glyph (tlast, or row
// MAX_ROWS-1) yields three result transactions, so the input is held off
// while the trailing cell rows leave the output register.
module glyph_outline_expander import goe_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ROW_BITS_W-1:0] s_tdata,  // [15:0] row_bits
	input  logic                  s_tuser,  // [0] odd_half
	input  logic                  s_tlast,  // last_row
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // cells_low, cells_mid, cells_high, out_row, pad
	output logic                  m_tlast   // glyph_done
);

	col_mask_t older_q, newer_q, t1_q, t2_q;
	row_idx_t  row_count_q, tail_row_q;
	logic      held_odd_q;
	logic [1:0] pend_q;
	logic      out_valid_q;
	result_t   out_q;

	logic      slot_free, s_acc, is_last, odd_now;
	col_mask_t cur;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (pend_q == 2'd0) && slot_free;
	assign s_acc     = s_tvalid && s_tready;
	assign cur       = to_columns(s_tdata);
	assign is_last   = s_tlast || (row_count_q >= row_idx_t'(MAX_ROWS - 1));
	assign odd_now   = (row_count_q == '0) ? s_tuser : held_odd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q     <= '0;
			newer_q     <= '0;
			t1_q        <= '0;
			t2_q        <= '0;
			row_count_q <= '0;
			tail_row_q  <= '0;
			held_odd_q  <= 1'b0;
			pend_q      <= 2'd0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (pend_q != 2'd0) begin
				if (slot_free) begin
					out_q.cells <= pack_cells('0, t1_q, t2_q, held_odd_q);
					out_q.row   <= tail_row_q;
					out_q.done  <= (pend_q == 2'd1);
					out_valid_q <= 1'b1;
					t2_q        <= t1_q;
					t1_q        <= '0;
					tail_row_q  <= tail_row_q + 1'b1;
					pend_q      <= pend_q - 1'b1;
				end
			end else if (s_acc) begin
				out_q.cells <= pack_cells(cur, newer_q, older_q, odd_now);
				out_q.row   <= row_count_q;
				out_q.done  <= 1'b0;
				out_valid_q <= 1'b1;
				held_odd_q  <= odd_now;
				if (is_last) begin
					t1_q        <= cur;
					t2_q        <= newer_q;
					tail_row_q  <= row_count_q + 1'b1;
					pend_q      <= 2'd2;
					older_q     <= '0;
					newer_q     <= '0;
					row_count_q <= '0;
				end else begin
					older_q     <= newer_q;
					newer_q     <= cur;
					row_count_q <= row_count_q + 1'b1;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - CELLS_W - ROW_IDX_W){1'b0}}, out_q.row, out_q.cells};
	assign m_tlast  = out_q.done;

	a_last_starts_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && is_last) |=> (pend_q == 2'd2))
		else $error("final row did not start trailing rows");

	a_done_ends_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done) |-> (pend_q == 2'd0 && row_count_q == '0))
		else $error("glyph_done with trailing rows or rows still pending");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_count_q <= row_idx_t'(MAX_ROWS - 1))
		else $error("row count past glyph height");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result changed");

endmodule
